[src/dsq_pkg.sv]
// Package for the dispense sequencer: queue sizing, command, phase and valve codes,
// and the structs passed between the sequencer and its order queue.
// No dependencies.
package dsq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int VALVE_COUNT = 6;
  localparam int VALVE_REGS  = 6;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((QW > CW) ? QW : CW) + 1;

  localparam int POS_W    = 10;
  localparam int DELAY_W  = 11;
  localparam int TARGET_W = 18;

  localparam logic [DELAY_W-1:0] SETTLE_MS = DELAY_W'(200);
  localparam logic [DELAY_W-1:0] DRIP_MS   = DELAY_W'(2000);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ENQ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_NEXT       = 3'd1,
    PH_MOVING     = 3'd2,
    PH_FILL_START = 3'd3,
    PH_FILLING    = 3'd4,
    PH_FILL_END   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    VA_NONE  = 2'd0,
    VA_OPEN  = 2'd1,
    VA_CLOSE = 2'd2
  } valve_act_t;

  typedef struct packed {
    logic [2:0]  valve;
    logic [11:0] grams;
  } order_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    order_t item;
  } queue_req_t;

  typedef struct packed {
    logic [CW-1:0] count;
    order_t        head_item;
  } queue_stat_t;

endpackage

[src/dsq_queue.sv]
// Ring queue of pour orders held in a synchronous memory with registered read.
// The head entry is always prefetched; a write to the slot being read is forwarded.
// Depends on dsq_pkg.
module dsq_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsq_pkg::queue_req_t  req,
  output dsq_pkg::queue_stat_t stat
);
  import dsq_pkg::*;

  order_t        mem [QUEUE_DEPTH];
  order_t        rd_r;
  logic [QW-1:0] head_r, head_nxt, head_inc, wr_slot;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] tail_sum;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      wr_slot = QW'(tail_sum - SW'(QUEUE_DEPTH));
    end else begin
      wr_slot = QW'(tail_sum);
    end
    head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    head_nxt  = head_r;
    count_nxt = count_r;
    if (req.clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (req.push) begin
      count_nxt = count_r + 1'b1;
    end else if (req.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wr_slot] <= req.item;
    end
    if (req.push && (wr_slot == head_nxt)) begin
      rd_r <= req.item;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign stat.count     = count_r;
  assign stat.head_item = rd_r;

endmodule

[src/dispense_sequencer.sv]
// Top level of the dispense sequencer: command decode, phase machine, delay timer,
// valve position registers and the output register. Depends on dsq_pkg and dsq_queue.
//
// Every input word is handled in the cycle it is accepted and gives exactly one output
// word, so the block takes one word per clock unless the output side holds it. The output
// register frees the input side whenever it is empty or being read in the same cycle.
// The queue memory prefetches its head entry with a registered read, ready for a pop.
module dispense_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // elapsed_ms[15:0], scale_grams[31:16], carrier_moving[32], valve_number[35:33],
  // pour_grams[47:36]
  input  logic [47:0] in_tdata,
  // command[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // carrier_move[0], carrier_target_mm[10:1], valve_action[12:11], valve_target[15:13],
  // enqueue_rejected[16], orders_waiting[20:17], phase_now[23:21]
  output logic [23:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import dsq_pkg::*;

  logic                       acc;
  cmd_t                       cmd;
  logic [15:0]                elapsed;
  logic signed [15:0]         scale;
  logic                       moving;
  logic [2:0]                 vnum;
  logic [11:0]                grams;

  logic [POS_W-1:0]           pos_r [VALVE_REGS];
  phase_t                     phase_r, phase_nxt;
  logic [DELAY_W-1:0]         delay_r, delay_nxt;
  logic [2:0]                 valve_r, valve_nxt;
  logic [11:0]                grams_r, grams_nxt;
  logic signed [TARGET_W-1:0] target_r, target_nxt;

  queue_req_t                 q_req;
  queue_stat_t                q_stat;

  logic                       c_move;
  logic [POS_W-1:0]           c_tgt;
  valve_act_t                 v_act;
  logic [2:0]                 v_tgt;
  logic                       rej;

  logic                       out_valid_r;
  logic [23:0]                out_data_r;

  assign acc     = in_tvalid && in_tready;
  assign cmd     = cmd_t'(in_tuser);
  assign elapsed = in_tdata[15:0];
  assign scale   = $signed(in_tdata[31:16]);
  assign moving  = in_tdata[32];
  assign vnum    = in_tdata[35:33];
  assign grams   = in_tdata[47:36];

  dsq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .stat  (q_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VALVE_REGS; i++) begin
        pos_r[i] <= '0;
      end
    end else if (cfg_wr_en && (32'(cfg_index) < VALVE_REGS)) begin
      pos_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    delay_nxt  = delay_r;
    valve_nxt  = valve_r;
    grams_nxt  = grams_r;
    target_nxt = target_r;
    q_req      = '0;
    q_req.item = order_t'({vnum, grams});
    c_move     = 1'b0;
    c_tgt      = '0;
    v_act      = VA_NONE;
    v_tgt      = '0;
    rej        = 1'b0;
    case (cmd)
      CMD_START: begin
        phase_nxt = (q_stat.count == '0) ? PH_IDLE : PH_NEXT;
      end
      CMD_STOP: begin
        phase_nxt   = PH_IDLE;
        q_req.clear = 1'b1;
      end
      CMD_ENQ: begin
        if ((32'(q_stat.count) >= QUEUE_DEPTH) || (32'(vnum) >= VALVE_COUNT)) begin
          rej = 1'b1;
        end else begin
          q_req.push = 1'b1;
        end
      end
      default: begin
        if (delay_r != '0) begin
          if (elapsed < 16'(delay_r)) begin
            delay_nxt = delay_r - elapsed[DELAY_W-1:0];
          end else begin
            delay_nxt = '0;
          end
        end else begin
          case (phase_r)
            PH_NEXT: begin
              if (q_stat.count == '0) begin
                phase_nxt = PH_IDLE;
              end else begin
                q_req.pop = 1'b1;
                valve_nxt = q_stat.head_item.valve;
                grams_nxt = q_stat.head_item.grams;
                c_move    = 1'b1;
                if (32'(q_stat.head_item.valve) < VALVE_REGS) begin
                  c_tgt = pos_r[q_stat.head_item.valve];
                end
                phase_nxt = PH_MOVING;
              end
            end
            PH_MOVING: begin
              if (!moving) begin
                delay_nxt = SETTLE_MS;
                phase_nxt = PH_FILL_START;
              end
            end
            PH_FILL_START: begin
              target_nxt = TARGET_W'(scale) + $signed({6'b0, grams_r});
              v_act      = VA_OPEN;
              v_tgt      = valve_r;
              phase_nxt  = PH_FILLING;
            end
            PH_FILLING: begin
              if (TARGET_W'(scale) >= target_r) begin
                v_act     = VA_CLOSE;
                v_tgt     = valve_r;
                delay_nxt = DRIP_MS;
                phase_nxt = PH_FILL_END;
              end
            end
            PH_FILL_END: begin
              if (q_stat.count == '0) begin
                phase_nxt = PH_IDLE;
                c_move    = 1'b1;
              end else begin
                phase_nxt = PH_NEXT;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    endcase
    if (!acc) begin
      q_req.push  = 1'b0;
      q_req.pop   = 1'b0;
      q_req.clear = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      delay_r  <= '0;
      valve_r  <= '0;
      grams_r  <= '0;
      target_r <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      delay_r  <= delay_nxt;
      valve_r  <= valve_nxt;
      grams_r  <= grams_nxt;
      target_r <= target_nxt;
    end
  end

  // The count seen here is the one after this word, which the queue shows in the cycle after.
  logic [CW-1:0] count_after;
  always_comb begin
    count_after = q_stat.count;
    if (q_req.clear) begin
      count_after = '0;
    end else if (q_req.push) begin
      count_after = q_stat.count + 1'b1;
    end else if (q_req.pop) begin
      count_after = q_stat.count - 1'b1;
    end
  end

  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= {phase_nxt, 4'(count_after), rej, v_tgt, v_act, c_tgt, c_move};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_stat.count) <= QUEUE_DEPTH)
    else $error("order count exceeds queue depth");

  a_open_then_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (v_act == VA_OPEN)) |=> (phase_r == PH_FILLING))
    else $error("valve opened without entering the filling phase");

  a_close_then_drip: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (v_act == VA_CLOSE)) |=> ((delay_r == DRIP_MS) && (phase_r == PH_FILL_END)))
    else $error("valve closed without starting the drip delay");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (cmd == CMD_STOP)) |=> ((q_stat.count == '0) && (phase_r == PH_IDLE)))
    else $error("stop did not clear the queue");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_tvalid)
    else $error("accepted word produced no output word");
`endif

endmodule
